@@ design/blit_rect_clip_with_source_scale_unit_defines.svh @@
// Assertion macros for the blit clip unit
`ifndef BLIT_RECT_CLIP_WITH_SOURCE_SCALE_UNIT_DEFINES_SVH
`define BLIT_RECT_CLIP_WITH_SOURCE_SCALE_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset
`define BRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with the consequent checked in the cycle after the antecedent
`define BRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/brc_pkg.sv @@
// Shared constants for the blit clip unit
`default_nettype none
package brc_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_BITS       = 15;
  localparam int IDX_BITS       = 2;
  localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(1920);
  localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(1080);

  typedef enum logic [IDX_BITS-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_t;
endpackage
`default_nettype wire

@@ design/blit_rect_clip_with_source_scale_unit.sv @@
// Throughput: one clip request per cycle while no result is held under
// out_stall; the divide is one quotient bit per stage over COORD_BITS
// stages, four lanes side by side.
// The whole pipe holds while a result waits under out_stall.
// Reset (rst, synchronous) empties the pipe and loads a 1920 x 1080 surface.
`default_nettype none
`include "blit_rect_clip_with_source_scale_unit_defines.svh"
module blit_rect_clip_with_source_scale_unit #(
  parameter int COORD_BITS = brc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brc_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [brc_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  src_left,
  input  logic signed [COORD_BITS-1:0]  src_top,
  input  logic signed [COORD_BITS-1:0]  src_right,
  input  logic signed [COORD_BITS-1:0]  src_bottom,
  input  logic signed [COORD_BITS-1:0]  dst_left,
  input  logic signed [COORD_BITS-1:0]  dst_top,
  input  logic signed [COORD_BITS-1:0]  dst_right,
  input  logic signed [COORD_BITS-1:0]  dst_bottom,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_src_left,
  output logic signed [COORD_BITS-1:0]  out_src_top,
  output logic signed [COORD_BITS-1:0]  out_src_right,
  output logic signed [COORD_BITS-1:0]  out_src_bottom,
  output logic signed [COORD_BITS-1:0]  out_dst_left,
  output logic signed [COORD_BITS-1:0]  out_dst_top,
  output logic signed [COORD_BITS-1:0]  out_dst_right,
  output logic signed [COORD_BITS-1:0]  out_dst_bottom,
  output logic                          empty_res
);
  import brc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int W  = ((CB > CFG_BITS) ? CB : CFG_BITS) + 2;
  localparam int NL = 4;  // lanes: right, bottom, left, top

  typedef logic [CB-1:0] u_t;

  // Fields that ride along the divide stages
  typedef struct packed {
    logic signed [CB-1:0] sl, st, sr, sb;
    logic signed [CB-1:0] dl, dt, dr, db;
    logic                 empty;
    u_t                   dw, dh;
  } carry_t;

  // Configuration registers
  logic [CFG_BITS-1:0] surface_width, surface_height;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= WIDTH_RST;
      surface_height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH)  surface_width  <= cfg_data;
      if (cfg_index == REG_HEIGHT) surface_height <= cfg_data;
    end
  end

  // Global advance: the pipe moves unless a result is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage A: extents, reject test, overhangs, clipped destination
  logic signed [W-1:0] slx, stx, srx, sbx, dlx, dtx, drx, dbx, wx, hx;
  logic signed [W-1:0] swx, shx, dwx, dhx;
  logic                rej;
  carry_t              a_c;
  u_t                  a_ovh [NL];
  u_t                  a_ext [NL];

  always_comb begin
    slx = W'(src_left);   stx = W'(src_top);
    srx = W'(src_right);  sbx = W'(src_bottom);
    dlx = W'(dst_left);   dtx = W'(dst_top);
    drx = W'(dst_right);  dbx = W'(dst_bottom);
    wx  = $signed({{(W-CFG_BITS){1'b0}}, surface_width});
    hx  = $signed({{(W-CFG_BITS){1'b0}}, surface_height});
    swx = srx - slx;  shx = sbx - stx;
    dwx = drx - dlx;  dhx = dbx - dtx;
    rej = (dlx >= wx) || (drx < 0) || (dtx >= hx) || (dbx < 0) ||
          (swx <= 0) || (shx <= 0) || (dwx <= 0) || (dhx <= 0);
    a_c.sl = src_left;  a_c.st = src_top;
    a_c.sr = src_right; a_c.sb = src_bottom;
    a_c.dl = (dlx < 0) ? '0 : dst_left;
    a_c.dt = (dtx < 0) ? '0 : dst_top;
    a_c.dr = (drx > wx) ? wx[CB-1:0] : dst_right;
    a_c.db = (dbx > hx) ? hx[CB-1:0] : dst_bottom;
    a_c.empty = rej;
    a_c.dw = rej ? u_t'(1) : dwx[CB-1:0];
    a_c.dh = rej ? u_t'(1) : dhx[CB-1:0];
    a_ovh[0] = (!rej && drx > wx) ? u_t'(drx - wx) : '0;
    a_ovh[1] = (!rej && dbx > hx) ? u_t'(dbx - hx) : '0;
    a_ovh[2] = (!rej && dlx < 0)  ? u_t'(-dlx)     : '0;
    a_ovh[3] = (!rej && dtx < 0)  ? u_t'(-dtx)     : '0;
    a_ext[0] = swx[CB-1:0];  a_ext[1] = shx[CB-1:0];
    a_ext[2] = swx[CB-1:0];  a_ext[3] = shx[CB-1:0];
  end

  logic   ra_v;
  carry_t ra_c;
  u_t     ra_ovh [NL];
  u_t     ra_ext [NL];
  always_ff @(posedge clk) begin
    if (rst) ra_v <= 1'b0;
    else if (en) ra_v <= in_valid;
    if (en) begin
      ra_c   <= a_c;
      ra_ovh <= a_ovh;
      ra_ext <= a_ext;
    end
  end

  // Divide stage registers; entry 0 is loaded by stage B
  logic   dv_v   [CB+1];
  carry_t dv_c   [CB+1];
  u_t     dv_rem [CB+1][NL];
  u_t     dv_low [CB+1][NL];
  u_t     dv_q   [CB+1][NL];

  // Stage B: overhang times source extent, split into divide start values
  logic [2*CB-1:0] b_p [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) b_p[l] = ra_ovh[l] * ra_ext[l];
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= ra_v;
    if (en) begin
      dv_c[0] <= ra_c;
      for (int l = 0; l < NL; l++) begin
        dv_rem[0][l] <= b_p[l][2*CB-1:CB];
        dv_low[0][l] <= b_p[l][CB-1:0];
        dv_q[0][l]   <= '0;
      end
    end
  end

  // Divide stages: one quotient bit per stage, per lane
  for (genvar j = 0; j < CB; j++) begin : g_div
    logic [CB:0] t   [NL];
    logic [CB:0] dif [NL];
    logic        ge  [NL];
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        t[l]   = {dv_rem[j][l], dv_low[j][l][CB-1]};
        dif[l] = t[l] - {1'b0, ((l % 2) == 1) ? dv_c[j].dh : dv_c[j].dw};
        ge[l]  = !dif[l][CB];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
      if (en) begin
        dv_c[j+1] <= dv_c[j];
        for (int l = 0; l < NL; l++) begin
          dv_rem[j+1][l] <= ge[l] ? dif[l][CB-1:0] : t[l][CB-1:0];
          dv_low[j+1][l] <= {dv_low[j][l][CB-2:0], 1'b0};
          dv_q[j+1][l]   <= {dv_q[j][l][CB-2:0], ge[l]};
        end
      end
    end
  end

  // Output stage: apply trims, zero on reject
  carry_t fc;
  assign fc = dv_c[CB];
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[CB];
    if (en) begin
      empty_res <= fc.empty;
      if (fc.empty) begin
        out_src_left <= '0;  out_src_top <= '0;
        out_src_right <= '0; out_src_bottom <= '0;
        out_dst_left <= '0;  out_dst_top <= '0;
        out_dst_right <= '0; out_dst_bottom <= '0;
      end else begin
        out_src_right  <= fc.sr - $signed(dv_q[CB][0]);
        out_src_bottom <= fc.sb - $signed(dv_q[CB][1]);
        out_src_left   <= fc.sl + $signed(dv_q[CB][2]);
        out_src_top    <= fc.st + $signed(dv_q[CB][3]);
        out_dst_left   <= fc.dl;  out_dst_top    <= fc.dt;
        out_dst_right  <= fc.dr;  out_dst_bottom <= fc.db;
      end
    end
  end

  // Checks
  `BRC_ASSERT_IMP(a_empty_zero, clk, rst, out_valid && empty_res,
    out_dst_left == 0 && out_dst_right == 0 && out_src_left == 0 && out_src_right == 0)
  `BRC_ASSERT_IMP(a_dst_order, clk, rst, out_valid && !empty_res,
    out_dst_left >= 0 && out_dst_top >= 0 && out_dst_left <= out_dst_right)
  `BRC_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_src_left) && $stable(empty_res))
endmodule
`default_nettype wire
